[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("implication check failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/wse_pkg.sv]
// Types, opcodes and decode function of the stack execute unit
package wse_pkg;

    typedef struct packed {
        logic [7:0]         kind;
        logic signed [63:0] immediate;
        logic               start_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] top_value;
        logic [6:0]         stack_count;
        logic               trapped;
    } out_item_t;

    localparam logic [7:0] OP_UNREACHABLE = 8'h00;
    localparam logic [7:0] OP_DROP        = 8'h1A;
    localparam logic [7:0] OP_SELECT      = 8'h1B;
    localparam logic [7:0] OP_LOCAL_GET   = 8'h20;
    localparam logic [7:0] OP_LOCAL_SET   = 8'h21;
    localparam logic [7:0] OP_LOCAL_TEE   = 8'h22;
    localparam logic [7:0] OP_I32_LOAD    = 8'h28;
    localparam logic [7:0] OP_I32_STORE   = 8'h36;
    localparam logic [7:0] OP_I32_CONST   = 8'h41;
    localparam logic [7:0] OP_I64_CONST   = 8'h42;
    localparam logic [7:0] OP_I32_EQZ     = 8'h45;
    localparam logic [7:0] OP_I32_EQ      = 8'h46;
    localparam logic [7:0] OP_I32_NE      = 8'h47;
    localparam logic [7:0] OP_I32_LT_S    = 8'h48;
    localparam logic [7:0] OP_I32_LT_U    = 8'h49;
    localparam logic [7:0] OP_I32_GT_S    = 8'h4A;
    localparam logic [7:0] OP_I32_GT_U    = 8'h4B;
    localparam logic [7:0] OP_I32_LE_S    = 8'h4C;
    localparam logic [7:0] OP_I32_LE_U    = 8'h4D;
    localparam logic [7:0] OP_I32_GE_S    = 8'h4E;
    localparam logic [7:0] OP_I32_GE_U    = 8'h4F;
    localparam logic [7:0] OP_I32_ADD     = 8'h6A;
    localparam logic [7:0] OP_I32_SUB     = 8'h6B;
    localparam logic [7:0] OP_I32_MUL     = 8'h6C;
    localparam logic [7:0] OP_I32_DIV_S   = 8'h6D;
    localparam logic [7:0] OP_I32_DIV_U   = 8'h6E;
    localparam logic [7:0] OP_I32_REM_S   = 8'h6F;
    localparam logic [7:0] OP_I32_REM_U   = 8'h70;
    localparam logic [7:0] OP_I32_AND     = 8'h71;
    localparam logic [7:0] OP_I32_OR      = 8'h72;
    localparam logic [7:0] OP_I32_XOR     = 8'h73;
    localparam logic [7:0] OP_I32_SHL     = 8'h74;
    localparam logic [7:0] OP_I32_SHR_S   = 8'h75;
    localparam logic [7:0] OP_I32_SHR_U   = 8'h76;
    localparam logic [7:0] OP_I32_ROTL    = 8'h77;
    localparam logic [7:0] OP_I32_ROTR    = 8'h78;
    localparam logic [7:0] OP_I64_ADD     = 8'h7C;
    localparam logic [7:0] OP_I64_SUB     = 8'h7D;
    localparam logic [7:0] OP_I64_MUL     = 8'h7E;
    localparam logic [7:0] OP_I32_WRAP    = 8'hA7;
    localparam logic [7:0] OP_I64_EXT_S   = 8'hAC;
    localparam logic [7:0] OP_I64_EXT_U   = 8'hAD;

    typedef enum logic [4:0] {
        CLS_NOP, CLS_UNREACH, CLS_DROP, CLS_SELECT, CLS_LGET, CLS_LSET, CLS_LTEE,
        CLS_CONST32, CLS_CONST64, CLS_LOAD, CLS_STORE, CLS_EQZ, CLS_ALU32, CLS_MUL32,
        CLS_DIV32, CLS_ADD64, CLS_SUB64, CLS_MUL64, CLS_WRAP, CLS_EXTS
    } op_class_t;

    typedef struct packed {
        op_class_t  cls;
        logic [1:0] npops;
        logic       keep_sp;
        logic       push;
        logic       multi;
    } op_info_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_POP_RD, ST_POP_WB, ST_EXEC, ST_MULDIV,
        ST_WRITE, ST_PEEK_RD, ST_PEEK_WB, ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic frame_clear;
        logic pop_capture;
        logic exec;
        logic md_step;
        logic write;
        logic peek_capture;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic       start_frame;
        logic       trapped;
        logic [1:0] npops;
        logic       multi;
        logic       md_done;
    } dp_status_t;

    function automatic op_info_t decode_op(input logic [7:0] kind);
        op_info_t info;
        info = '{cls: CLS_NOP, npops: 2'd0, keep_sp: 1'b0, push: 1'b0, multi: 1'b0};
        case (kind)
            OP_UNREACHABLE: info.cls = CLS_UNREACH;
            OP_DROP: begin
                info.cls = CLS_DROP; info.npops = 2'd1;
            end
            OP_SELECT: begin
                info.cls = CLS_SELECT; info.npops = 2'd3; info.push = 1'b1;
            end
            OP_LOCAL_GET: begin
                info.cls = CLS_LGET; info.push = 1'b1;
            end
            OP_LOCAL_SET: begin
                info.cls = CLS_LSET; info.npops = 2'd1;
            end
            OP_LOCAL_TEE: begin
                info.cls = CLS_LTEE; info.npops = 2'd1; info.keep_sp = 1'b1;
            end
            OP_I32_CONST: begin
                info.cls = CLS_CONST32; info.push = 1'b1;
            end
            OP_I64_CONST: begin
                info.cls = CLS_CONST64; info.push = 1'b1;
            end
            OP_I32_LOAD: begin
                info.cls = CLS_LOAD; info.npops = 2'd1; info.push = 1'b1;
            end
            OP_I32_STORE: begin
                info.cls = CLS_STORE; info.npops = 2'd2;
            end
            OP_I32_EQZ: begin
                info.cls = CLS_EQZ; info.npops = 2'd1; info.push = 1'b1;
            end
            OP_I32_MUL: begin
                info.cls = CLS_MUL32; info.npops = 2'd2; info.push = 1'b1;
                info.multi = 1'b1;
            end
            OP_I32_DIV_S, OP_I32_DIV_U, OP_I32_REM_S, OP_I32_REM_U: begin
                info.cls = CLS_DIV32; info.npops = 2'd2; info.push = 1'b1;
                info.multi = 1'b1;
            end
            OP_I64_ADD: begin
                info.cls = CLS_ADD64; info.npops = 2'd2; info.push = 1'b1;
            end
            OP_I64_SUB: begin
                info.cls = CLS_SUB64; info.npops = 2'd2; info.push = 1'b1;
            end
            OP_I64_MUL: begin
                info.cls = CLS_MUL64; info.npops = 2'd2; info.push = 1'b1;
                info.multi = 1'b1;
            end
            OP_I32_WRAP, OP_I64_EXT_U: begin
                info.cls = CLS_WRAP; info.npops = 2'd1; info.push = 1'b1;
            end
            OP_I64_EXT_S: begin
                info.cls = CLS_EXTS; info.npops = 2'd1; info.push = 1'b1;
            end
            default: begin
                if ((kind >= OP_I32_EQ && kind <= OP_I32_GE_U) ||
                    (kind >= OP_I32_ADD && kind <= OP_I32_ROTR)) begin
                    info.cls = CLS_ALU32; info.npops = 2'd2; info.push = 1'b1;
                end
            end
        endcase
        return info;
    endfunction

endpackage

[rtl/core/wse_ctrl.sv]
// Controller state machine that sequences one instruction through the datapath
module wse_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  wse_pkg::dp_status_t   status,
    output wse_pkg::dp_cmd_t      cmd
);

    wse_pkg::state_t state_reg, state_next;
    logic [1:0]      pops_reg, pops_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wse_pkg::ST_CLEAR;
            pops_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pops_reg      <= pops_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        pops_next      = pops_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            wse_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) state_next = wse_pkg::ST_IDLE;
            end
            wse_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = wse_pkg::ST_DECODE;
                end
            end
            wse_pkg::ST_DECODE: begin
                if (status.start_frame) begin
                    cmd.frame_clear = 1'b1;
                    state_next      = wse_pkg::ST_PEEK_RD;
                end else if (status.trapped) begin
                    state_next = wse_pkg::ST_PEEK_RD;
                end else if (status.npops != 2'd0) begin
                    pops_next  = status.npops;
                    state_next = wse_pkg::ST_POP_RD;
                end else begin
                    state_next = wse_pkg::ST_EXEC;
                end
            end
            wse_pkg::ST_POP_RD: state_next = wse_pkg::ST_POP_WB;
            wse_pkg::ST_POP_WB: begin
                cmd.pop_capture = 1'b1;
                pops_next       = pops_reg - 2'd1;
                state_next      = (pops_reg == 2'd1) ? wse_pkg::ST_EXEC : wse_pkg::ST_POP_RD;
            end
            wse_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.multi ? wse_pkg::ST_MULDIV : wse_pkg::ST_WRITE;
            end
            wse_pkg::ST_MULDIV: begin
                cmd.md_step = 1'b1;
                if (status.md_done) state_next = wse_pkg::ST_WRITE;
            end
            wse_pkg::ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = wse_pkg::ST_PEEK_RD;
            end
            wse_pkg::ST_PEEK_RD: state_next = wse_pkg::ST_PEEK_WB;
            wse_pkg::ST_PEEK_WB: begin
                cmd.peek_capture = 1'b1;
                state_next       = wse_pkg::ST_DONE;
            end
            wse_pkg::ST_DONE: begin
                // hold until the output slot is free
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wse_pkg::ST_IDLE;
                end
            end
            default: state_next = wse_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

[rtl/core/wse_datapath.sv]
// Datapath: operand stack, locals, banked linear memory, ALU, multiplier and divider
module wse_datapath #(
    parameter int STACK_DEPTH  = 64,
    parameter int NUM_LOCALS   = 16,
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wse_pkg::in_item_t     in_item,
    input  wse_pkg::dp_cmd_t      cmd,
    output wse_pkg::dp_status_t   status,
    output wse_pkg::out_item_t    out_item
);

    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int SIW   = $clog2(STACK_DEPTH);
    localparam int LIW   = (NUM_LOCALS > 1) ? $clog2(NUM_LOCALS) : 1;
    localparam int WORDS = MEMORY_BYTES / 4;
    localparam int WAW   = $clog2(WORDS);
    localparam int AW    = WAW + 2;

    wse_pkg::in_item_t  item_reg;
    wse_pkg::op_info_t  info;
    wse_pkg::out_item_t out_reg;

    logic [SPW-1:0] sp_reg;
    logic           trap_reg;
    logic [63:0]    p0_reg, p1_reg, p2_reg;
    logic [63:0]    res_reg, top_reg;

    logic [63:0]    stack_mem [STACK_DEPTH];
    logic [63:0]    stack_rd_reg;
    logic [SIW-1:0] stack_rd_idx;
    logic           stack_full;

    logic [63:0]            locals_mem [NUM_LOCALS];
    logic [NUM_LOCALS-1:0]  lvalid_reg;
    logic [63:0]            loc_rd_reg;
    logic                   loc_vld_rd_reg;
    logic                   loc_in_range;
    logic [LIW-1:0]         lidx;

    logic [WAW-1:0] clr_cnt_reg;
    logic [31:0]    mem_addr;
    logic           mem_ok;
    logic [WAW-1:0] bank_idx   [4];
    logic [7:0]     bank_wdata [4];
    logic [7:0]     bank_rd    [4];
    logic           bank_we;
    logic [31:0]    load_word;

    logic [4:0]  md_cnt_reg;
    logic        md_done;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod_reg, acc_reg;
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic        neg_q_reg, neg_r_reg, dz_reg;
    logic [32:0] div_shift, div_diff;
    logic [31:0] div_result;
    logic        div_signed;

    logic [31:0] a32, b32;
    logic [63:0] push_val;

    assign info = wse_pkg::decode_op(item_reg.kind);
    assign a32  = p0_reg[31:0];
    assign b32  = p1_reg[31:0];

    function automatic logic [31:0] alu32(input logic [7:0] op, input logic [31:0] a,
                                          input logic [31:0] b);
        logic [4:0]  n;
        logic [63:0] dbl;
        logic [31:0] r;
        n   = b[4:0];
        dbl = {a, a};
        case (op)
            wse_pkg::OP_I32_EQ:    r = 32'(a == b);
            wse_pkg::OP_I32_NE:    r = 32'(a != b);
            wse_pkg::OP_I32_LT_S:  r = 32'($signed(a) < $signed(b));
            wse_pkg::OP_I32_LT_U:  r = 32'(a < b);
            wse_pkg::OP_I32_GT_S:  r = 32'($signed(a) > $signed(b));
            wse_pkg::OP_I32_GT_U:  r = 32'(a > b);
            wse_pkg::OP_I32_LE_S:  r = 32'($signed(a) <= $signed(b));
            wse_pkg::OP_I32_LE_U:  r = 32'(a <= b);
            wse_pkg::OP_I32_GE_S:  r = 32'($signed(a) >= $signed(b));
            wse_pkg::OP_I32_GE_U:  r = 32'(a >= b);
            wse_pkg::OP_I32_ADD:   r = a + b;
            wse_pkg::OP_I32_SUB:   r = a - b;
            wse_pkg::OP_I32_AND:   r = a & b;
            wse_pkg::OP_I32_OR:    r = a | b;
            wse_pkg::OP_I32_XOR:   r = a ^ b;
            wse_pkg::OP_I32_SHL:   r = a << n;
            wse_pkg::OP_I32_SHR_S: r = 32'($signed(a) >>> n);
            wse_pkg::OP_I32_SHR_U: r = a >> n;
            wse_pkg::OP_I32_ROTL:  r = dbl[63:32] << n | a >> (6'd32 - {1'b0, n});
            default:               r = 32'(dbl >> n);
        endcase
        if (op == wse_pkg::OP_I32_ROTL) begin
            r = (n == 5'd0) ? a : ((a << n) | (a >> (6'd32 - {1'b0, n})));
        end
        return r;
    endfunction

    // ---------------- operand stack ----------------
    assign stack_rd_idx = SIW'(sp_reg - SPW'(1));
    assign stack_full   = (sp_reg >= SPW'(STACK_DEPTH));

    always_ff @(posedge aclk) begin
        stack_rd_reg <= stack_mem[stack_rd_idx];
        if (cmd.write && info.push && !stack_full) begin
            stack_mem[SIW'(sp_reg)] <= push_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg   <= '0;
            trap_reg <= 1'b0;
        end else if (cmd.frame_clear) begin
            sp_reg   <= '0;
            trap_reg <= 1'b0;
        end else begin
            if (cmd.pop_capture && !info.keep_sp && sp_reg != '0) begin
                sp_reg <= sp_reg - SPW'(1);
            end
            if (cmd.write && info.push && !stack_full) begin
                sp_reg <= sp_reg + SPW'(1);
            end
            if (cmd.write && info.cls == wse_pkg::CLS_UNREACH) begin
                trap_reg <= 1'b1;
            end
        end
    end

    // ---------------- locals ----------------
    assign loc_in_range = ($unsigned(item_reg.immediate) < 64'(NUM_LOCALS));
    assign lidx         = loc_in_range ? item_reg.immediate[LIW-1:0] : '0;

    always_ff @(posedge aclk) begin
        loc_rd_reg     <= locals_mem[lidx];
        loc_vld_rd_reg <= lvalid_reg[lidx];
        if (cmd.write && loc_in_range &&
            (info.cls == wse_pkg::CLS_LSET || info.cls == wse_pkg::CLS_LTEE)) begin
            locals_mem[lidx] <= p0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.frame_clear) begin
            lvalid_reg <= '0;
        end else if (cmd.write && loc_in_range &&
                     (info.cls == wse_pkg::CLS_LSET || info.cls == wse_pkg::CLS_LTEE)) begin
            lvalid_reg[lidx] <= 1'b1;
        end
    end

    // ---------------- linear memory, four byte banks ----------------
    assign mem_addr = p0_reg[31:0];
    assign mem_ok   = (({1'b0, mem_addr} + 33'd4) <= 33'(MEMORY_BYTES));
    assign bank_we  = cmd.clear_step ||
                      (cmd.write && info.cls == wse_pkg::CLS_STORE && mem_ok);

    always_comb begin
        logic [1:0]    k;
        logic [AW-1:0] ba;
        for (int j = 0; j < 4; j++) begin
            k             = 2'(j) - mem_addr[1:0];
            ba            = mem_addr[AW-1:0] + AW'(k);
            bank_idx[j]   = cmd.clear_step ? clr_cnt_reg : ba[AW-1:2];
            bank_wdata[j] = cmd.clear_step ? 8'd0 : 8'(p1_reg[31:0] >> {k, 3'b000});
        end
    end

    for (genvar gj = 0; gj < 4; gj++) begin : g_bank
        logic [7:0] mem [WORDS];
        always_ff @(posedge aclk) begin
            bank_rd[gj] <= mem[bank_idx[gj]];
            if (bank_we) begin
                mem[bank_idx[gj]] <= bank_wdata[gj];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            load_word[k*8 +: 8] = bank_rd[2'(mem_addr[1:0] + 2'(k))];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + WAW'(1);
        end
    end

    // ---------------- multiplier and divider ----------------
    always_comb begin
        case (md_cnt_reg)
            5'd1:    begin mul_x = a32;           mul_y = p1_reg[63:32]; end
            5'd2:    begin mul_x = p0_reg[63:32]; mul_y = b32;           end
            default: begin mul_x = a32;           mul_y = b32;           end
        endcase
    end

    assign div_shift = {dr_reg, dq_reg[31]};
    assign div_diff  = div_shift - {1'b0, dd_reg};
    assign div_signed = (item_reg.kind == wse_pkg::OP_I32_DIV_S) ||
                        (item_reg.kind == wse_pkg::OP_I32_REM_S);

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_x) * 64'(mul_y);
        if (cmd.exec) begin
            md_cnt_reg <= 5'd0;
            dq_reg     <= (div_signed && a32[31]) ? (32'd0 - a32) : a32;
            dd_reg     <= (div_signed && b32[31]) ? (32'd0 - b32) : b32;
            dr_reg     <= 32'd0;
            neg_q_reg  <= div_signed && (a32[31] ^ b32[31]);
            neg_r_reg  <= div_signed && a32[31];
            dz_reg     <= (b32 == 32'd0);
        end else if (cmd.md_step) begin
            md_cnt_reg <= md_cnt_reg + 5'd1;
            case (md_cnt_reg)
                5'd1:    acc_reg <= prod_reg;
                5'd2,
                5'd3:    acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                default: acc_reg <= acc_reg;
            endcase
            // one restoring step per cycle
            if (!div_diff[32]) begin
                dr_reg <= div_diff[31:0];
                dq_reg <= {dq_reg[30:0], 1'b1};
            end else begin
                dr_reg <= div_shift[31:0];
                dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        case (info.cls)
            wse_pkg::CLS_MUL32: md_done = (md_cnt_reg == 5'd0);
            wse_pkg::CLS_MUL64: md_done = (md_cnt_reg == 5'd3);
            default:            md_done = (md_cnt_reg == 5'd31);
        endcase
    end

    always_comb begin
        if (dz_reg) begin
            div_result = 32'd0;
        end else if (item_reg.kind == wse_pkg::OP_I32_REM_S ||
                     item_reg.kind == wse_pkg::OP_I32_REM_U) begin
            div_result = neg_r_reg ? (32'd0 - dr_reg) : dr_reg;
        end else begin
            div_result = neg_q_reg ? (32'd0 - dq_reg) : dq_reg;
        end
    end

    // ---------------- simple results ----------------
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            case (info.cls)
                wse_pkg::CLS_SELECT:  res_reg <= (p2_reg[31:0] != 32'd0) ? p0_reg : p1_reg;
                wse_pkg::CLS_CONST32: res_reg <= {32'd0, item_reg.immediate[31:0]};
                wse_pkg::CLS_CONST64: res_reg <= item_reg.immediate;
                wse_pkg::CLS_EQZ:     res_reg <= 64'(a32 == 32'd0);
                wse_pkg::CLS_ALU32:   res_reg <= {32'd0, alu32(item_reg.kind, a32, b32)};
                wse_pkg::CLS_ADD64:   res_reg <= p0_reg + p1_reg;
                wse_pkg::CLS_SUB64:   res_reg <= p0_reg - p1_reg;
                wse_pkg::CLS_EXTS:    res_reg <= {{32{a32[31]}}, a32};
                default:              res_reg <= {32'd0, a32};
            endcase
        end
    end

    always_comb begin
        case (info.cls)
            wse_pkg::CLS_LGET:  push_val = loc_vld_rd_reg ? loc_rd_reg : 64'd0;
            wse_pkg::CLS_LOAD:  push_val = mem_ok ? {32'd0, load_word} : 64'd0;
            wse_pkg::CLS_MUL32: push_val = {32'd0, prod_reg[31:0]};
            wse_pkg::CLS_MUL64: push_val = acc_reg;
            wse_pkg::CLS_DIV32: push_val = {32'd0, div_result};
            default:            push_val = res_reg;
        endcase
    end

    // ---------------- input, pops, peek and output ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_in) item_reg <= in_item;
        if (cmd.pop_capture) begin
            p0_reg <= (sp_reg != '0) ? stack_rd_reg : 64'd0;
            p1_reg <= p0_reg;
            p2_reg <= p1_reg;
        end
        if (cmd.peek_capture) top_reg <= (sp_reg != '0) ? stack_rd_reg : 64'd0;
        if (cmd.out_load) begin
            out_reg.top_value   <= top_reg;
            out_reg.stack_count <= 7'(sp_reg);
            out_reg.trapped     <= trap_reg;
        end
    end

    assign status.md_done     = md_done;
    assign status.clear_last  = (clr_cnt_reg == WAW'(WORDS - 1));
    assign status.start_frame = item_reg.start_frame;
    assign status.trapped     = trap_reg;
    assign status.npops       = info.npops;
    assign status.multi       = info.multi;
    assign out_item           = out_reg;

endmodule

[rtl/core/wasm_stack_execute_unit.sv]
// Top level of the WebAssembly integer stack execute unit
// Executes one decoded instruction per request, one request at a time, and returns
// the new top of stack, stack count and trap flag. After reset the unit sweeps
// linear memory to zero before it takes a request. A request is decoded, pops the
// stack entries it needs (0 to 3), executes, steps the multiplier or divider for
// i32.mul, i64.mul and the i32 divide and remainder ops, writes its result and
// reads the new top of stack; start_frame and requests after a trap skip straight
// to the top-of-stack read. The operand stack memory has a registered read, so
// each pop and the final top-of-stack read pass a read state and a capture state.
// The shared 32x32 multiplier serves both multiplies; the divider makes one bit per
// cycle. A finished result waits in an output register while the next is taken.
module wasm_stack_execute_unit #(
    parameter int STACK_DEPTH  = 64,
    parameter int NUM_LOCALS   = 16,
    parameter int MEMORY_BYTES = 65536
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wse_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output wse_pkg::out_item_t  m_payload
);

    wse_pkg::dp_cmd_t    cmd;
    wse_pkg::dp_status_t status;

    wse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wse_datapath #(
        .STACK_DEPTH  (STACK_DEPTH),
        .NUM_LOCALS   (NUM_LOCALS),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_payload),
        .cmd      (cmd),
        .status   (status),
        .out_item (m_payload)
    );

endmodule

[rtl/core/wse_checker.sv]
// Port-level checker for the stack execute unit and its bind
`include "assert_macros.svh"

module wse_checker #(
    parameter int STACK_DEPTH = 64
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input wse_pkg::in_item_t   s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input wse_pkg::out_item_t  m_payload
);

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_fire, !s_ready)
    `ASSERT_IMPLY(a_count_bound, aclk, aresetn, m_valid, m_payload.stack_count <= STACK_DEPTH)
    `ASSERT_IMPLY(a_empty_top_zero, aclk, aresetn, m_valid && m_payload.stack_count == 7'd0,
        m_payload.top_value == 64'sd0)

endmodule

bind wasm_stack_execute_unit wse_checker #(.STACK_DEPTH(STACK_DEPTH)) u_wse_checker (.*);
